/* design/markov_link_fading_table_core_assert.svh */
// assertion macros used by the core design file
// each expects clk and arst_n in the scope of use
`ifndef MARKOV_LINK_FADING_TABLE_CORE_ASSERT_SVH
`define MARKOV_LINK_FADING_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define MLFT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MLFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/mlft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlft_pkg
// Types, constants and tables of the satellite link fading table.
// ----------------------------------------------------------------------------
package mlft_pkg;

	localparam int LINK_SLOTS = 256;
	localparam int SLOT_AW    = $clog2(LINK_SLOTS);

	// link conditions
	localparam logic [1:0] COND_CLEAR    = 2'd0;
	localparam logic [1:0] COND_SHADOWED = 2'd1;
	localparam logic [1:0] COND_BLOCKED  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MARKOV_EN = 2'd0;
	localparam logic [1:0] REG_SHADOW_EN = 2'd1;
	localparam logic [1:0] REG_ENV       = 2'd2;
	localparam logic [1:0] REG_DWELL     = 2'd3;

	// elevation limits, 1/256 degree
	localparam logic [14:0] ELEV_MIN = 15'd1280;
	localparam logic [14:0] ELEV_MAX = 15'd23040;

	typedef struct packed {
		logic [1:0]         cond;
		logic [31:0]        ctime;
		logic signed [15:0] gain;
		logic signed [15:0] shadow;
	} slot_t;

	typedef struct packed {
		logic        start;
		logic [39:0] power;
	} pd_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] db;
	} pd_resp_t;

	// cumulative thresholds [band][current][edge]
	localparam logic [15:0] CUM_THR [3][3][2] = '{
		'{'{16'd62260, 16'd64881}, '{16'd19661, 16'd58983}, '{16'd13108, 16'd32768}},
		'{'{16'd55706, 16'd62260}, '{16'd9831,  16'd55706}, '{16'd6554,  16'd22938}},
		'{'{16'd45876, 16'd58983}, '{16'd6554,  16'd49152}, '{16'd3277,  16'd16384}}
	};

	// rician k factor, linear, q16, for 2..20 dB
	localparam logic [22:0] KLIN [19] = '{
		23'd103868, 23'd130762, 23'd164619, 23'd207243, 23'd260904, 23'd328458,
		23'd413504, 23'd520571, 23'd655360, 23'd825049, 23'd1038676, 23'd1307615,
		23'd1646190, 23'd2072430, 23'd2609035, 23'd3284581, 23'd4135042,
		23'd5205709, 23'd6553600
	};

	// shadow innovation scale per environment, q16
	localparam logic [18:0] SHADOW_COEF [8] = '{
		19'd454047, 19'd454047, 19'd340535, 19'd227023,
		19'd170268, 19'd170268, 19'd170268, 19'd170268
	};

	typedef logic [15:0] tab19_t [19];

	// largest r with r*r*den <= num
	function automatic logic [15:0] isqrt_ratio(logic [63:0] num, logic [63:0] den);
		logic [15:0] r;
		logic [15:0] t;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (16'd1 << b);
			if (64'(t) * 64'(t) * den <= num) begin
				r = t;
			end
		end
		return r;
	endfunction

	// line-of-sight amplitude per k factor
	function automatic tab19_t build_a_tab();
		tab19_t tab;
		for (int i = 0; i < 19; i++) begin
			tab[i] = isqrt_ratio(64'(KLIN[i]) << 32, 64'(KLIN[i]) + 64'd65536);
		end
		return tab;
	endfunction

	// scatter deviation per k factor
	function automatic tab19_t build_s_tab();
		tab19_t tab;
		for (int i = 0; i < 19; i++) begin
			tab[i] = isqrt_ratio(64'd1 << 47, 64'(KLIN[i]) + 64'd65536);
		end
		return tab;
	endfunction

	localparam tab19_t CLR_A = build_a_tab();
	localparam tab19_t CLR_S = build_s_tab();

	// saturate to 16 bits signed
	function automatic logic signed [15:0] sat16(logic signed [39:0] v);
		if (v > 40'sd32767) begin
			return 16'sh7fff;
		end else if (v < -40'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

/* design/mlft_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlft_ram
// Single-port-write, registered-read generic RAM.
// ----------------------------------------------------------------------------
module mlft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/mlft_pow_db.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlft_pow_db
// Converts a q32 power to dB in q7.8: normalize, 16 squaring steps of log2,
// then scale by 10*log10(2).
// ----------------------------------------------------------------------------
module mlft_pow_db (
	input  logic               clk,
	input  logic               arst_n,
	input  mlft_pkg::pd_req_t  req,
	output mlft_pkg::pd_resp_t resp
);

	typedef enum logic [2:0] {S_IDLE, S_NORM, S_LOG, S_MUL, S_FIN} pd_state_t;

	pd_state_t          state_q;
	logic [39:0]        p_q;
	logic [5:0]         m_q;
	logic [30:0]        y_q;
	logic [15:0]        frac_q;
	logic [3:0]         cnt_q;
	logic signed [41:0] prod_q;
	logic               done_q;
	logic signed [15:0] db_q;

	logic [61:0]        y_sq;
	logic [31:0]        y_nx;
	logic signed [6:0]  exp_s;
	logic signed [22:0] l2;
	logic signed [41:0] rnd;

	// one squaring step of the fractional log
	always_comb begin
		y_sq  = 62'(y_q) * 62'(y_q);
		y_nx  = y_sq[61:30];
		exp_s = $signed({1'b0, m_q}) - 7'sd32;
		l2    = $signed({exp_s, frac_q});
		rnd   = (prod_q + 42'sd8388608) >>> 24;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// zero power answers at once, otherwise done stays low
					done_q <= req.start && (req.power == '0);
					if (req.start) begin
						if (req.power == '0) begin
							db_q <= 16'sh8000;
						end else begin
							p_q     <= req.power;
							m_q     <= 6'd39;
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					if (p_q[39:32] == 8'd0) begin
						p_q <= p_q << 8;
						m_q <= m_q - 6'd8;
					end else if (!p_q[39]) begin
						p_q <= p_q << 1;
						m_q <= m_q - 6'd1;
					end else begin
						y_q     <= p_q[39:9];
						frac_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_LOG;
					end
				end
				S_LOG: begin
					if (y_nx[31]) begin
						y_q    <= y_nx[31:1];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						y_q    <= y_nx[30:0];
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= 42'(l2) * 42'sd197283;
					state_q <= S_FIN;
				end
				S_FIN: begin
					db_q    <= mlft_pkg::sat16(40'(rnd));
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign resp.done = done_q;
	assign resp.db   = db_q;

endmodule

/* design/markov_link_fading_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_link_fading_table_core
// Three-condition land mobile satellite link table with fading gain and
// correlated shadow update, one evaluation transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one evaluation transaction: link
//   slot, elevation, time and random draws. Output channel (out_valid/
//   out_ready) returns one result per transaction: condition, gain, shadow
//   value and the change/check flags.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   it only while no transaction is in flight; the block does not enforce it.
//   A blocked, shadowed or undrawn outcome goes from accept through the
//   read, draw, gain, shadow and write-back states. A clear draw takes the
//   Rician path in place of the gain state: the states S_C1 to S_C5 and the dB
//   converter (normalize, squaring steps, scale; zero power skips the steps).
//   Throughput: one transaction at a time; the slot table is one RAM read at
//   accept and one write at the end, so the next transaction is taken the
//   cycle after the result is registered.
//   Reset clears all slot valid bits at once; the table RAM needs no sweep.
//   A stalled receiver holds the result register; the block finishes the
//   next transaction and waits to write back until that register is free.
// ----------------------------------------------------------------------------
`include "markov_link_fading_table_core_assert.svh"

module markov_link_fading_table_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  link_index,
	input  logic [14:0] elevation,
	input  logic [31:0] now_ms,
	input  logic [15:0] uniform_draw,
	input  logic signed [15:0] normal_first,
	input  logic signed [15:0] normal_second,
	input  logic signed [15:0] normal_third,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  link_condition,
	output logic signed [15:0] fading_gain,
	output logic signed [15:0] shadow_fading,
	output logic        condition_changed,
	output logic        transition_checked
);

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_DRAW, S_GAIN, S_C1, S_C2, S_C3, S_C4, S_C5,
		S_LOGW, S_SHAD, S_WB
	} core_state_t;

	core_state_t state_q;

	// configuration registers
	logic        markov_en_q;
	logic        shadow_en_q;
	logic [2:0]  env_q;
	logic [15:0] dwell_q;

	// transaction payload
	logic [mlft_pkg::SLOT_AW-1:0] idx_q;
	logic [14:0]        e_q;
	logic [31:0]        now_q;
	logic [15:0]        u_q;
	logic signed [15:0] n1_q;
	logic signed [15:0] n2_q;
	logic signed [15:0] n3_q;

	// working state
	logic [mlft_pkg::LINK_SLOTS-1:0] valid_q;
	mlft_pkg::slot_t    ent_q;
	logic               present_q;
	logic [4:0]         kidx_q;
	logic [1:0]         nxt_q;
	logic               checked_q;
	logic               changed_q;
	logic signed [15:0] mean1_q;
	logic signed [15:0] mean2_q;
	logic signed [21:0] re_q;
	logic signed [21:0] im_q;
	logic signed [43:0] sqre_q;
	logic signed [43:0] sqim_q;

	// result register
	logic               out_valid_q;
	logic [1:0]         out_cond_q;
	logic signed [15:0] out_gain_q;
	logic signed [15:0] out_shadow_q;
	logic               out_changed_q;
	logic               out_checked_q;

	// table RAM
	logic                   ram_we;
	logic                   ram_re;
	mlft_pkg::slot_t        ram_rdata;
	logic [$bits(mlft_pkg::slot_t)-1:0] ram_rdata_raw;

	mlft_pkg::pd_req_t  pd_req;
	mlft_pkg::pd_resp_t pd_resp;

	logic in_acc;
	logic wb_go;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign wb_go    = (state_q == S_WB) && (!out_valid_q || out_ready);
	assign ram_re   = in_acc;
	assign ram_we   = wb_go && present_q;
	assign ram_rdata = mlft_pkg::slot_t'(ram_rdata_raw);

	mlft_ram #(
		.WIDTH($bits(mlft_pkg::slot_t)),
		.DEPTH(mlft_pkg::LINK_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ent_q),
		.re    (ram_re),
		.raddr (link_index),
		.rdata (ram_rdata_raw)
	);

	mlft_pow_db u_pow_db (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pd_req),
		.resp   (pd_resp)
	);

	assign pd_req.start = (state_q == S_C5);
	assign pd_req.power = 40'(sqre_q + sqim_q);

	// k factor from elevation: 1280 + (e-1278)/5, clamped, to whole dB
	logic [14:0] kv;
	logic [30:0] kq_prod;
	logic [12:0] kq8;
	logic [12:0] kq8_c;
	logic [4:0]  k_db;
	always_comb begin
		kv      = e_q - 15'd1278;
		kq_prod = 31'(kv) * 31'd52429;
		kq8     = 13'd1280 + 13'(kq_prod[30:18]);
		if (e_q <= 15'd2560) begin
			kq8_c = 13'd512;
		end else if (kq8 > 13'd5120) begin
			kq8_c = 13'd5120;
		end else begin
			kq8_c = kq8;
		end
		k_db = 5'((kq8_c + 13'd128) >> 8);
	end

	// draw decision and non-clear means
	logic [1:0]         cur;
	logic               dwelling;
	logic               draw;
	logic [1:0]         band;
	logic [1:0]         nxt;
	logic [14:0]        w1;
	logic [31:0]        q1_prod;
	logic [16:0]        w2;
	logic [30:0]        q2_prod;
	logic signed [16:0] m1;
	logic signed [16:0] m2;
	always_comb begin
		cur      = (ent_q.cond > mlft_pkg::COND_BLOCKED) ? mlft_pkg::COND_BLOCKED
			: ent_q.cond;
		dwelling = (ent_q.ctime != 32'd0) && ((now_q < ent_q.ctime) ||
			((now_q - ent_q.ctime) < {16'd0, dwell_q}));
		draw     = markov_en_q && present_q && !dwelling;
		band     = (e_q > 15'd15360) ? 2'd0 : ((e_q > 15'd7680) ? 2'd1 : 2'd2);
		if (u_q < mlft_pkg::CUM_THR[band][cur][0]) begin
			nxt = mlft_pkg::COND_CLEAR;
		end else if (u_q < mlft_pkg::CUM_THR[band][cur][1]) begin
			nxt = mlft_pkg::COND_SHADOWED;
		end else begin
			nxt = mlft_pkg::COND_BLOCKED;
		end
		w1      = 15'd23045 - e_q;
		q1_prod = 32'(w1) * 32'd52429;
		m1      = -17'sd512 - $signed({4'd0, q1_prod[31:19]});
		w2      = 17'd69130 - 17'(e_q) * 17'd3;
		q2_prod = 31'(w2[16:2]) * 31'd52429;
		m2      = -17'sd3968 - $signed({4'd0, q2_prod[30:18]});
	end

	// non-clear gains
	logic signed [19:0] g1;
	logic signed [19:0] g2;
	logic signed [19:0] g2_c;
	always_comb begin
		g1   = 20'(mean1_q) + ((20'(n1_q) * 20'sd3 + 20'sd8) >>> 4);
		g2   = 20'(mean2_q) + ((20'(n1_q) * 20'sd5 + 20'sd8) >>> 4);
		g2_c = (g2 > -20'sd2560) ? -20'sd2560 : g2;
	end

	// rician components
	logic signed [32:0] prod_re;
	logic signed [32:0] prod_im;
	always_comb begin
		prod_re = 33'($signed({1'b0, mlft_pkg::CLR_S[kidx_q]})) * 33'(n1_q);
		prod_im = 33'($signed({1'b0, mlft_pkg::CLR_S[kidx_q]})) * 33'(n2_q);
	end

	// correlated shadow update
	logic signed [36:0] sh_sum;
	logic signed [36:0] sh_new;
	always_comb begin
		sh_sum = (37'(ent_q.shadow) <<< 19) +
			37'($signed({1'b0, mlft_pkg::SHADOW_COEF[env_q]})) * 37'(n3_q) +
			37'sd524288;
		sh_new = sh_sum >>> 20;
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			markov_en_q <= 1'b1;
			shadow_en_q <= 1'b0;
			env_q       <= 3'd1;
			dwell_q     <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mlft_pkg::REG_MARKOV_EN: markov_en_q <= cfg_data[0];
				mlft_pkg::REG_SHADOW_EN: shadow_en_q <= cfg_data[0];
				mlft_pkg::REG_ENV:       env_q       <= cfg_data[2:0];
				mlft_pkg::REG_DWELL:     dwell_q     <= cfg_data;
				default:                 dwell_q     <= dwell_q;
			endcase
		end
	end

	// main sequencer: read, modify, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !wb_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						idx_q <= link_index;
						if (elevation < mlft_pkg::ELEV_MIN) begin
							e_q <= mlft_pkg::ELEV_MIN;
						end else if (elevation > mlft_pkg::ELEV_MAX) begin
							e_q <= mlft_pkg::ELEV_MAX;
						end else begin
							e_q <= elevation;
						end
						now_q   <= now_ms;
						u_q     <= uniform_draw;
						n1_q    <= normal_first;
						n2_q    <= normal_second;
						n3_q    <= normal_third;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (valid_q[idx_q]) begin
						ent_q <= ram_rdata;
					end else begin
						ent_q.cond   <= mlft_pkg::COND_CLEAR;
						ent_q.ctime  <= now_q;
						ent_q.gain   <= '0;
						ent_q.shadow <= '0;
					end
					present_q <= valid_q[idx_q] || markov_en_q || shadow_en_q;
					kidx_q    <= k_db - 5'd2;
					state_q   <= S_DRAW;
				end
				S_DRAW: begin
					checked_q <= draw;
					changed_q <= draw && (nxt != cur);
					nxt_q     <= nxt;
					mean1_q   <= (m1 < -17'sd3840) ? -16'sd3840 : 16'(m1);
					mean2_q   <= (m2 < -17'sd8960) ? -16'sd8960 : 16'(m2);
					if (draw) begin
						ent_q.cond <= nxt;
						if (nxt != cur) begin
							ent_q.ctime <= now_q;
						end
					end
					state_q <= (draw && nxt == mlft_pkg::COND_CLEAR) ? S_C1 : S_GAIN;
				end
				S_GAIN: begin
					if (checked_q) begin
						ent_q.gain <= (nxt_q == mlft_pkg::COND_SHADOWED)
							? mlft_pkg::sat16(40'(g1)) : mlft_pkg::sat16(40'(g2_c));
					end
					state_q <= S_SHAD;
				end
				S_C1: begin
					re_q <= $signed({6'd0, mlft_pkg::CLR_A[kidx_q]}) +
						22'((prod_re + 33'sd2048) >>> 12);
					state_q <= S_C2;
				end
				S_C2: begin
					im_q    <= 22'((prod_im + 33'sd2048) >>> 12);
					state_q <= S_C3;
				end
				S_C3: begin
					sqre_q  <= 44'(re_q) * 44'(re_q);
					state_q <= S_C4;
				end
				S_C4: begin
					sqim_q  <= 44'(im_q) * 44'(im_q);
					state_q <= S_C5;
				end
				S_C5: begin
					state_q <= S_LOGW;
				end
				S_LOGW: begin
					if (pd_resp.done) begin
						ent_q.gain <= pd_resp.db;
						state_q    <= S_SHAD;
					end
				end
				S_SHAD: begin
					if (shadow_en_q && present_q) begin
						ent_q.shadow <= mlft_pkg::sat16(40'(sh_new));
					end
					state_q <= S_WB;
				end
				S_WB: begin
					if (wb_go) begin
						if (present_q) begin
							valid_q[idx_q] <= 1'b1;
						end
						out_valid_q   <= 1'b1;
						out_cond_q    <= present_q ? ent_q.cond : mlft_pkg::COND_CLEAR;
						out_gain_q    <= present_q ? ent_q.gain : 16'sd0;
						out_shadow_q  <= present_q ? ent_q.shadow : 16'sd0;
						out_changed_q <= changed_q;
						out_checked_q <= checked_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign link_condition     = out_cond_q;
	assign fading_gain        = out_gain_q;
	assign shadow_fading      = out_shadow_q;
	assign condition_changed  = out_changed_q;
	assign transition_checked = out_checked_q;

	// checks
	`MLFT_ASSERT_NEXT(a_one_in_flight, in_acc, !in_ready)
	`MLFT_ASSERT_NOW(a_cond_legal, out_valid_q, out_cond_q != 2'd3)
	`MLFT_ASSERT_NOW(a_changed_needs_check, out_valid_q && out_changed_q, out_checked_q)
	`MLFT_ASSERT_NOW(a_log_done_when_waiting, pd_resp.done, state_q == S_LOGW)
	`MLFT_ASSERT_NOW(a_write_has_slot, ram_we, wb_go && present_q)

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the satellite link fading table. A behavioral
// predictor keeps its own slot table and registers and computes the result of
// every accepted evaluation; results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb;

	// expected result of one evaluation
	typedef struct {
		logic [1:0]  cond;
		logic [15:0] gain;
		logic [15:0] shadow;
		logic        changed;
		logic        checked;
	} fade_result_t;

	// predictor of the link table and the queue of pending results
	class fade_scoreboard;
		bit          mk_en;
		bit          sh_en;
		int          env;
		longint      dwell;
		bit          valid [256];
		int          cond [256];
		longint      ctime [256];
		longint      gain [256];
		longint      shadow [256];
		fade_result_t pending [$];
		int          errors;
		int          results;
		int          draws;
		int          changes;

		function void clear();
			mk_en = 1; sh_en = 0; env = 1; dwell = 100;
			for (int i = 0; i < 256; i++) begin
				valid[i] = 0; cond[i] = 0; ctime[i] = 0; gain[i] = 0; shadow[i] = 0;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				mlft_pkg::REG_MARKOV_EN: mk_en = val[0];
				mlft_pkg::REG_SHADOW_EN: sh_en = val[0];
				mlft_pkg::REG_ENV:       env = val[2:0];
				mlft_pkg::REG_DWELL:     dwell = val;
			endcase
		endfunction

		function longint fdiv(longint n, longint d);
			if (n >= 0) return n / d;
			return -((-n + d - 1) / d);
		endfunction

		function longint rdiv(longint n, longint d);
			return fdiv(n + d / 2, d);
		endfunction

		function longint sat(longint v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		function longint root(longint unsigned v);
			longint unsigned r, b;
			r = 0; b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b; r = (r >> 1) + b;
				end else r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function longint to_db(longint unsigned p);
			int m;
			longint unsigned y;
			longint fr;
			if (p == 0) return -32768;
			m = 63; fr = 0;
			while (p[m] == 0) m--;
			y = (m > 30) ? (p >> (m - 30)) : (p << (30 - m));
			for (int i = 0; i < 16; i++) begin
				y = (y * y) >> 30;
				fr <<= 1;
				if (y >= (64'd1 << 31)) begin
					y >>= 1; fr |= 1;
				end
			end
			return sat(rdiv((longint'(m - 32) * 65536 + fr) * 197283, 64'sd1 << 24));
		endfunction

		function longint rician_db(longint e, longint n1, longint n2);
			longint kq, k, re, im;
			longint unsigned kl, a, s;
			if (e <= 2560) kq = 512;
			else begin
				kq = 2560 + rdiv(e - 7680, 5);
				if (kq < 512) kq = 512;
				if (kq > 5120) kq = 5120;
			end
			k = (kq + 128) / 256;
			kl = mlft_pkg::KLIN[(k - 2) % 19];
			a = root((kl << 32) / (kl + 65536));
			s = root((64'd1 << 47) / (kl + 65536));
			re = longint'(a) + rdiv(longint'(s) * n1, 4096);
			im = rdiv(longint'(s) * n2, 4096);
			return to_db(longint'(re * re) + longint'(im * im));
		endfunction

		function void open_slot(int i, longint now);
			valid[i] = 1; cond[i] = 0; ctime[i] = now; gain[i] = 0; shadow[i] = 0;
		endfunction

		// note an accepted evaluation and queue its result
		function void note_eval(logic [7:0] li, logic [14:0] el, logic [31:0] nw,
				logic [15:0] u, logic signed [15:0] a1, logic signed [15:0] a2,
				logic signed [15:0] a3);
			fade_result_t r;
			int i, band, cur, nxt;
			longint e, now, g, mean;
			bit stay;
			i = li; e = el; now = nw;
			r.changed = 0; r.checked = 0;
			if (e < 1280) e = 1280;
			if (e > 23040) e = 23040;
			if (mk_en) begin
				if (!valid[i]) open_slot(i, now);
				stay = ctime[i] != 0 && (now < ctime[i] || now - ctime[i] < dwell);
				if (!stay) begin
					band = e > 15360 ? 0 : (e > 7680 ? 1 : 2);
					cur = cond[i] > 2 ? 2 : cond[i];
					if (u < mlft_pkg::CUM_THR[band][cur][0]) nxt = mlft_pkg::COND_CLEAR;
					else if (u < mlft_pkg::CUM_THR[band][cur][1])
						nxt = mlft_pkg::COND_SHADOWED;
					else nxt = mlft_pkg::COND_BLOCKED;
					if (nxt == mlft_pkg::COND_CLEAR) g = rician_db(e, a1, a2);
					else if (nxt == mlft_pkg::COND_SHADOWED) begin
						mean = -1280 - rdiv(15360 - e, 10);
						if (mean < -3840) mean = -3840;
						g = mean + rdiv(3 * longint'(a1), 16);
					end else begin
						mean = -5120 - rdiv(3 * (15360 - e), 20);
						if (mean < -8960) mean = -8960;
						g = mean + rdiv(5 * longint'(a1), 16);
						if (g > -2560) g = -2560;
					end
					r.checked = 1; draws++;
					if (nxt != cur) begin
						r.changed = 1; ctime[i] = now; changes++;
					end
					cond[i] = nxt;
					gain[i] = sat(g);
				end
			end
			if (sh_en) begin
				if (!valid[i]) open_slot(i, now);
				shadow[i] = sat(rdiv(shadow[i] * 524288 +
					longint'(mlft_pkg::SHADOW_COEF[env]) * longint'(a3), 1048576));
			end
			if (valid[i]) begin
				r.cond = cond[i]; r.gain = gain[i]; r.shadow = shadow[i];
			end else begin
				r.cond = 0; r.gain = 0; r.shadow = 0;
			end
			pending.push_back(r);
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(logic [1:0] c, logic [15:0] g, logic [15:0] s,
				logic ch, logic ck);
			fade_result_t x;
			results++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result cond=%0d gain=%0d", c, g);
				return;
			end
			x = pending.pop_front();
			if (x.cond !== c || x.gain !== g || x.shadow !== s ||
					x.changed !== ch || x.checked !== ck) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
						x.cond, $signed(x.gain), $signed(x.shadow), x.changed, x.checked,
						c, $signed(g), $signed(s), ch, ck);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = 0;
	logic [15:0] cfg_data = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [7:0]  link_index = 0;
	logic [14:0] elevation = 15'd1280;
	logic [31:0] now_ms = 0;
	logic [15:0] uniform_draw = 0;
	logic signed [15:0] normal_first = 0;
	logic signed [15:0] normal_second = 0;
	logic signed [15:0] normal_third = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  link_condition;
	logic signed [15:0] fading_gain;
	logic signed [15:0] shadow_fading;
	logic        condition_changed;
	logic        transition_checked;

	fade_scoreboard board = new();
	bit          sending_done = 0;
	longint      clock_ms = 1000;

	markov_link_fading_table_core dut (.*);

	always #2 clk = ~clk;

	// run limit
	initial begin
		#8000000;
		$display("Regression FAIL");
		$finish;
	end

	// note accepted evaluations
	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			board.note_eval(link_index, elevation, now_ms, uniform_draw,
				normal_first, normal_second, normal_third);

	// result receiver with random stalls
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check_result(link_condition, fading_gain, shadow_fading,
					condition_changed, transition_checked);
				w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
				if (w != 0) begin
					out_ready <= 0;
					repeat (w) @(posedge clk);
				end
				out_ready <= 1;
			end else if (!out_ready) out_ready <= 1;
		end
	end

	// send one evaluation and wait for its acceptance; valid stays high
	// afterwards until the next send or an explicit idle
	task automatic send_eval(logic [7:0] li, logic [14:0] el, logic [31:0] nw,
			logic [15:0] u, logic [15:0] a1, logic [15:0] a2, logic [15:0] a3,
			int gap);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		link_index <= li; elevation <= el; now_ms <= nw; uniform_draw <= u;
		normal_first <= a1; normal_second <= a2; normal_third <= a3;
		do @(posedge clk); while (!in_ready);
	endtask

	// wait until every result is back plus slack for a busy block
	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		board.write_reg(idx, val);
		@(posedge clk);
	endtask

	// random evaluation, mostly a small set of links with advancing time
	task automatic rand_eval(int gap);
		logic [7:0] li;
		logic [14:0] el;
		li = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
		case ($urandom_range(0, 5))
			0: el = 15'($urandom);
			1: el = 15'($urandom_range(0, 1280));
			default: el = 15'($urandom_range(1280, 23040));
		endcase
		clock_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 120) : $urandom_range(0, 400);
		send_eval(li, el, $urandom_range(0, 15) == 0 ? $urandom : 32'(clock_ms),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), gap);
	endtask

	initial begin
		int gap;
		int n;
		board.clear();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every condition, dwell and empty-slot cases
		send_eval(8'd0, 15'd1280, 32'd0, 16'd0, 16'sh7fff, 16'sh8000, 16'd0, 0);
		send_eval(8'd0, 15'd1280, 32'd0, 16'hffff, 16'sh8000, 16'sh7fff, 16'd0, 0);
		send_eval(8'd255, 15'h7fff, 32'hffffffff, 16'd40000, 16'sh8000, 16'd0, 16'd0, 0);
		send_eval(8'd255, 15'd0, 32'hffffffff, 16'hffff, 16'sh7fff, 16'd0, 16'd0, 0);
		send_eval(8'd1, 15'd23040, 32'd500, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		send_eval(8'd1, 15'd23040, 32'd550, 16'hffff, 16'd0, 16'd0, 16'd0, 0);
		send_eval(8'd1, 15'd2560, 32'd700, 16'd63000, 16'd100, 16'd0, 16'd0, 0);
		send_eval(8'd1, 15'd10000, 32'd100, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		send_eval(8'd1, 15'd7680, 32'd900, 16'd0, 16'sh8000, 16'sh8000, 16'd0, 0);
		send_eval(8'd2, 15'd15360, 32'd5, 16'd62260, 16'd0, 16'd0, 16'd0, 0);
		drain();
		write_reg(mlft_pkg::REG_SHADOW_EN, 16'hffff);
		write_reg(mlft_pkg::REG_ENV, 16'd0);
		send_eval(8'd3, 15'd20000, 32'd10, 16'd0, 16'd0, 16'd0, 16'sh7fff, 0);
		send_eval(8'd3, 15'd20000, 32'd20, 16'd0, 16'd0, 16'd0, 16'sh7fff, 0);
		drain();
		write_reg(mlft_pkg::REG_MARKOV_EN, 16'd0);
		send_eval(8'd4, 15'd20000, 32'd30, 16'd0, 16'd0, 16'd0, 16'sh8000, 0);
		send_eval(8'd4, 15'd20000, 32'd31, 16'd0, 16'd0, 16'd0, 16'sh8000, 0);
		drain();
		write_reg(mlft_pkg::REG_SHADOW_EN, 16'd0);
		send_eval(8'd5, 15'd20000, 32'd40, 16'd0, 16'd0, 16'd0, 16'd0, 0);
		drain();
		write_reg(mlft_pkg::REG_MARKOV_EN, 16'd1);

		// random phases over register settings
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(mlft_pkg::REG_MARKOV_EN, 16'(ph != 5));
			write_reg(mlft_pkg::REG_SHADOW_EN, 16'(ph % 2));
			write_reg(mlft_pkg::REG_ENV, 16'(ph));
			write_reg(mlft_pkg::REG_DWELL, ph == 2 ? 16'hffff : ph == 3 ? 16'd0 :
				16'($urandom_range(0, 300)));
			n = 200;
			for (int k = 0; k < n; k++) begin
				gap = (ph == 4) ? 0 : $urandom_range(0, 8);
				if (k == 100) begin
					in_valid <= 0;
					while (board.pending.size() != 0) @(posedge clk);
				end
				rand_eval(gap);
			end
		end
		drain();
		$display("evaluations=%0d draws=%0d condition changes=%0d over eight register phases",
			board.results, board.draws, board.changes);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+design
design/mlft_pkg.sv
design/mlft_ram.sv
design/mlft_pow_db.sv
design/markov_link_fading_table_core.sv
sim/tb.sv
